// ===== sv/adaptive_binary_range_encoder_macros.svh =====
// Assertion macros shared by the range encoder RTL.
`ifndef ADAPTIVE_BINARY_RANGE_ENCODER_MACROS_SVH
`define ADAPTIVE_BINARY_RANGE_ENCODER_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define ABRE_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ABRE_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the following cycle.
`define ABRE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/abre_pkg.sv =====
// Types and constants of the adaptive binary range encoder.
package abre_pkg;

   localparam int CMD_W       = 2;
   localparam int IN_IDX_W    = 13;
   localparam int PROB_W      = 11;
   localparam int ADAPT_SHIFT = 5;
   localparam int RANGE_W     = 32;
   localparam int LOW_W       = 33;
   localparam int BYTE_W      = 8;
   localparam int COUNT_W     = 32;

   localparam logic [PROB_W:0]      PROB_ONE    = 12'd2048;
   localparam logic [PROB_W-1:0]    PROB_INIT   = 11'd1024;
   localparam logic [RANGE_W-1:0]   TOP_LIMIT   = 32'h0100_0000;
   localparam logic [RANGE_W-1:0]   RANGE_RESET = 32'hFFFF_FFFF;
   localparam logic [BYTE_W-1:0]    HOLD_BYTE   = 8'hFF;
   localparam logic [COUNT_W-1:0]   PEND_MAX    = 32'hFFFF_FFFF;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADAPT  = 2'd0,
      CMD_DIRECT = 2'd1,
      CMD_FLUSH  = 2'd2
   } cmd_type;

endpackage

// ===== sv/abre_req_if.sv =====
// Request channel of the range encoder: valid/ready plus one command.
interface abre_req_if;
   import abre_pkg::*;

   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    cmd;
   logic [IN_IDX_W-1:0] prob_index;
   logic                bit_value;

   modport source (output valid, output cmd, output prob_index, output bit_value,
                   input ready);
   modport sink   (input valid, input cmd, input prob_index, input bit_value,
                   output ready);
endinterface

// ===== sv/abre_rsp_if.sv =====
// Result channel of the range encoder: valid/ready plus one compacted byte run.
interface abre_rsp_if;
   import abre_pkg::*;

   logic               valid;
   logic               ready;
   logic [BYTE_W-1:0]  lead_byte;
   logic [COUNT_W-1:0] fill_count;
   logic               fill_is_zero;
   logic               overflow;

   modport source (output valid, output lead_byte, output fill_count,
                   output fill_is_zero, output overflow, input ready);
   modport sink   (input valid, input lead_byte, input fill_count,
                   input fill_is_zero, input overflow, output ready);
endinterface

// ===== sv/adaptive_binary_range_encoder.sv =====
// A request passes through stage 0, stage 1 and stage 2; a settled byte run then leaves the output register.
// A new request may enter once stage 0 is empty and stage 1 is empty or moving on; stage 1 waits for stage 2
//   to drain, so the range multiply and the range update that follows it form the loop that limits the rate.
// Reset (synchronous, active high) clears the coder state, then sweeps the probability
//   memory to 1024, one entry a cycle, with req_bus.ready low until the sweep ends.
`include "adaptive_binary_range_encoder_macros.svh"

module adaptive_binary_range_encoder #(
   parameter int PROB_COUNT = 8192
) (
   input logic       clock,
   input logic       reset,
   abre_req_if.sink   req_bus,
   abre_rsp_if.source rsp_bus
);
   import abre_pkg::*;

   localparam int IDX_W = $clog2(PROB_COUNT);
   // index reduction is split at this bit position between accept and the memory read
   localparam int SPLIT = 6;

   // ---------------------------------------------------------------
   // Index modulo PROB_COUNT: restoring subtraction of shifted
   // multiples, upper steps at accept, lower steps ahead of the read.
   // ---------------------------------------------------------------
   function automatic logic [IN_IDX_W-1:0] reduce_hi(input logic [IN_IDX_W-1:0] v);
      logic [IN_IDX_W-1:0] r;
      logic [31:0]         m;
      r = v;
      for (int k = IN_IDX_W - 1; k >= SPLIT; k--) begin
         m = 32'(PROB_COUNT) << k;
         if (32'(r) >= m) begin
            r = r - m[IN_IDX_W-1:0];
         end
      end
      return r;
   endfunction

   function automatic logic [IDX_W-1:0] reduce_lo(input logic [IN_IDX_W-1:0] v);
      logic [IN_IDX_W-1:0] r;
      logic [31:0]         m;
      r = v;
      for (int k = SPLIT - 1; k >= 0; k--) begin
         m = 32'(PROB_COUNT) << k;
         if (32'(r) >= m) begin
            r = r - m[IN_IDX_W-1:0];
         end
      end
      return IDX_W'(r);
   endfunction

   // ---------------------------------------------------------------
   // Probability memory, one write and one read port, read registered
   // ---------------------------------------------------------------
   logic [PROB_W-1:0] prob_mem [PROB_COUNT];
   logic              mem_we;
   logic [IDX_W-1:0]  mem_waddr;
   logic [PROB_W-1:0] mem_wdata;
   logic [IDX_W-1:0]  mem_raddr;

   // clearing sweep after reset
   logic             clr_active_ff, clr_active_in;
   logic [IDX_W-1:0] clr_addr_ff, clr_addr_in;

   // stage 0: request captured, index half reduced
   logic                s0_valid_ff, s0_valid_in;
   logic [CMD_W-1:0]    s0_cmd_ff;
   logic                s0_bit_ff;
   logic [IN_IDX_W-1:0] s0_idx_ff;

   // stage 1: probability read back, multiply and write-back
   logic              s1_valid_ff, s1_valid_in;
   logic [CMD_W-1:0]  s1_cmd_ff;
   logic              s1_bit_ff;
   logic [IDX_W-1:0]  s1_addr_ff;
   logic [PROB_W-1:0] prob_rd_ff;

   // stage 2: range / low update, renormalisation and byte shift
   logic               s2_valid_ff, s2_valid_in;
   logic [CMD_W-1:0]   s2_cmd_ff;
   logic               s2_bit_ff;
   logic [RANGE_W-1:0] bound_ff;

   // coder state
   logic [LOW_W-1:0]   low_ff, low_in;
   logic [RANGE_W-1:0] range_ff, range_in;
   logic [BYTE_W-1:0]  held_ff, held_in;
   logic [COUNT_W-1:0] pend_ff, pend_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]  lead_ff;
   logic [COUNT_W-1:0] fill_ff;
   logic               fill_zero_ff;
   logic               ovf_ff;

   logic req_ready;
   logic req_fire;
   logic s0_go;
   logic s1_go;
   logic s2_go;

   // ---------------------------------------------------------------
   // Pipeline control. Stage 1 only multiplies once stage 2 has
   // drained, so the range it reads is settled. A new request may
   // enter as stage 1 moves on; its read then lands after that
   // stage's write-back, so no forwarding path is needed.
   // ---------------------------------------------------------------
   assign s2_go     = s2_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign s1_go     = s1_valid_ff && !s2_valid_ff;
   assign s0_go     = s0_valid_ff && (!s1_valid_ff || s1_go);
   assign req_ready = !clr_active_ff && !s0_valid_ff && (!s1_valid_ff || s1_go);
   assign req_fire  = req_bus.valid && req_ready;

   assign req_bus.ready = req_ready;

   always_comb begin
      s0_valid_in = req_fire ? 1'b1 : (s0_go ? 1'b0 : s0_valid_ff);
      s1_valid_in = s0_go ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);
      s2_valid_in = s1_go ? 1'b1 : (s2_go ? 1'b0 : s2_valid_ff);
   end

   // clearing sweep
   always_comb begin
      clr_active_in = clr_active_ff;
      clr_addr_in   = clr_addr_ff;
      if (clr_active_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == IDX_W'(PROB_COUNT - 1)) begin
            clr_active_in = 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------
   // Stage 1 arithmetic: split point and probability adaptation
   // ---------------------------------------------------------------
   logic [RANGE_W-1:0] bound_mul;
   logic [PROB_W:0]    up_delta;
   logic [PROB_W-1:0]  prob_new;

   always_comb begin
      bound_mul = 32'(range_ff[RANGE_W-1:PROB_W]) * 32'(prob_rd_ff);
      up_delta  = (PROB_ONE - {1'b0, prob_rd_ff}) >> ADAPT_SHIFT;
      if (s1_bit_ff) begin
         prob_new = prob_rd_ff - (prob_rd_ff >> ADAPT_SHIFT);
      end else begin
         prob_new = prob_rd_ff + up_delta[PROB_W-1:0];
      end
   end

   // write port: sweep owns it after reset, adaptive bits afterwards
   always_comb begin
      mem_we    = clr_active_ff || (s1_go && s1_cmd_ff == CMD_ADAPT);
      mem_waddr = clr_active_ff ? clr_addr_ff : s1_addr_ff;
      mem_wdata = clr_active_ff ? PROB_INIT : prob_new;
      mem_raddr = reduce_lo(s0_idx_ff);
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         prob_mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (s0_go) begin
         prob_rd_ff <= prob_mem[mem_raddr];
      end
   end

   // ---------------------------------------------------------------
   // Stage 2: interval update, renormalisation, byte shift with
   // carry settlement of the held byte and the pending run
   // ---------------------------------------------------------------
   logic [LOW_W-1:0]   low_mid;
   logic [RANGE_W-1:0] range_mid;
   logic [RANGE_W-1:0] range_half;
   logic               do_shift;
   logic [31:0]        low_t;
   logic               low_c;
   logic               shift_emit;
   logic [COUNT_W-1:0] pend_base;

   always_comb begin
      low_mid    = low_ff;
      range_mid  = range_ff;
      range_half = range_ff >> 1;
      do_shift   = 1'b0;
      case (s2_cmd_ff)
         CMD_ADAPT: begin
            if (s2_bit_ff) begin
               low_mid   = low_ff + {1'b0, bound_ff};
               range_mid = range_ff - bound_ff;
            end else begin
               range_mid = bound_ff;
            end
            do_shift = range_mid < TOP_LIMIT;
         end
         CMD_DIRECT: begin
            range_mid = range_half;
            if (s2_bit_ff) begin
               low_mid = low_ff + {1'b0, range_half};
            end
            do_shift = range_mid < TOP_LIMIT;
         end
         CMD_FLUSH: begin
            do_shift = 1'b1;
         end
         default: begin
            do_shift = 1'b0;   // unused code: no effect
         end
      endcase

      low_t = low_mid[31:0];
      low_c = low_mid[LOW_W-1];
      // byte leaves unless it is 0xFF with no carry (then it joins the run)
      shift_emit = do_shift && (low_t[31:24] != HOLD_BYTE || low_c);
      pend_base  = shift_emit ? '0 : pend_ff;

      low_in   = low_ff;
      range_in = range_ff;
      held_in  = held_ff;
      pend_in  = pend_ff;
      if (s2_go) begin
         range_in = (do_shift && s2_cmd_ff != CMD_FLUSH) ? (range_mid << BYTE_W) : range_mid;
         low_in   = do_shift ? {1'b0, low_t[23:0], {BYTE_W{1'b0}}} : low_mid;
         if (shift_emit) begin
            held_in = low_t[31:24];
         end
         if (do_shift) begin
            pend_in = (pend_base == PEND_MAX) ? pend_base : pend_base + 1'b1;
         end
      end
   end

   always_comb begin
      if (s2_go && shift_emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // ---------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
         s0_valid_ff   <= 1'b0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         low_ff        <= '0;
         range_ff      <= RANGE_RESET;
         held_ff       <= '0;
         pend_ff       <= COUNT_W'(1);
      end else begin
         clr_active_ff <= clr_active_in;
         clr_addr_ff   <= clr_addr_in;
         s0_valid_ff   <= s0_valid_in;
         s1_valid_ff   <= s1_valid_in;
         s2_valid_ff   <= s2_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         low_ff        <= low_in;
         range_ff      <= range_in;
         held_ff       <= held_in;
         pend_ff       <= pend_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s0_cmd_ff <= req_bus.cmd;
         s0_bit_ff <= req_bus.bit_value;
         s0_idx_ff <= reduce_hi(req_bus.prob_index);
      end
      if (s0_go) begin
         s1_cmd_ff  <= s0_cmd_ff;
         s1_bit_ff  <= s0_bit_ff;
         s1_addr_ff <= mem_raddr;
      end
      if (s1_go) begin
         s2_cmd_ff <= s1_cmd_ff;
         s2_bit_ff <= s1_bit_ff;
         bound_ff  <= bound_mul;
      end
      if (s2_go && shift_emit) begin
         lead_ff      <= held_ff + {{(BYTE_W-1){1'b0}}, low_c};
         fill_ff      <= (pend_ff == '0) ? '0 : pend_ff - 1'b1;
         fill_zero_ff <= low_c;
         ovf_ff       <= (pend_ff == PEND_MAX);
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.lead_byte    = lead_ff;
   assign rsp_bus.fill_count   = fill_ff;
   assign rsp_bus.fill_is_zero = fill_zero_ff;
   assign rsp_bus.overflow     = ovf_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   // read-after-write interlock: never two requests ahead of the multiply
   `ABRE_ASSERT_ALWAYS(a_front_single, clock, reset, !(s0_valid_ff && s1_valid_ff), "two requests ahead of stage 2")
   // sweep runs with the pipeline empty
   `ABRE_ASSERT_IMPLY(a_clear_idle, clock, reset, clr_active_ff, !(s0_valid_ff || s1_valid_ff || s2_valid_ff), "request in flight during sweep")
   // renormalisation keeps the range at or above 2^24
   `ABRE_ASSERT_ALWAYS(a_range_norm, clock, reset, range_ff[RANGE_W-1:24] != '0, "range left unnormalised")
   // held byte always counted
   `ABRE_ASSERT_ALWAYS(a_pend_nonzero, clock, reset, pend_ff != '0, "pending count reached zero")
   // a settled byte run is presented next cycle
   `ABRE_ASSERT_NEXT(a_emit_shown, clock, reset, s2_go && shift_emit, rsp_valid_ff, "settled run not presented")
   // results appear only from the update stage
   `ABRE_ASSERT_IMPLY(a_rsp_source, clock, reset, $rose(rsp_valid_ff), $past(s2_go), "result raised without an update")

endmodule
